### rtl/bounded_top_k_sorted_queue_macros.svh
// Assertion macros shared by the bounded top-k sorted queue RTL.
`ifndef BOUNDED_TOP_K_SORTED_QUEUE_MACROS_SVH
`define BOUNDED_TOP_K_SORTED_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTKSQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTKSQ_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BTKSQ_ASSERT(label, clk, rst, prop, msg)
`define BTKSQ_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### rtl/btksq_pkg.sv
// Types and constants shared by the bounded top-k sorted queue.
package btksq_pkg;

   localparam int WordWidth = 32;

   // One stored hypothesis; x sits in the lowest bits when packed.
   typedef struct packed {
      logic signed [WordWidth-1:0] score;
      logic [WordWidth-1:0]        heading;
      logic [WordWidth-1:0]        y;
      logic [WordWidth-1:0]        x;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   localparam int CapWidth = 6;

endpackage

### rtl/btksq_cell.sv
// One slot of the sorted insertion chain.
module btksq_cell (
   input  logic                   clock,
   input  logic                   occupied,
   input  logic                   prev_gt,
   input  btksq_pkg::entry_type   new_entry,
   input  btksq_pkg::entry_type   prev_entry,
   input  btksq_pkg::entry_type   next_entry,
   input  btksq_pkg::cell_ctrl_type ctrl,
   output logic                   gt,
   output btksq_pkg::entry_type   entry
);
   import btksq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // An empty slot loses to any newcomer; the result is monotone along the chain.
   assign gt = !occupied || (new_entry.score > entry_ff.score);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         // The previous slot was displaced, so its content moves down here.
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt) begin
            entry_in = new_entry;
         end
      end else if (ctrl.drain) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/bounded_top_k_sorted_queue.sv
// Insert: one beat per cycle while idle, result-free, the whole chain of cells updates in that cycle.
// Drain: one result beat per cycle from the head cell, unless the output stalls, while the chain
// shifts up; the drain state is registered on acceptance and the first result beat is registered from it.
// No input is taken while a drain is emitting: the input is held off until the last result beat
// of a drain, or the single beat of an empty drain, has been registered, plus any stall.
// Synchronous active-high reset empties the queue and sets capacity to min(32, depth).
`include "bounded_top_k_sorted_queue_macros.svh"

module bounded_top_k_sorted_queue #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pose_x, pose_y, pose_heading, score
   input  logic [btksq_pkg::EntryWidth-1:0]    req_tdata,
   // operation
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_x, out_y, out_heading, out_score
   output logic [btksq_pkg::EntryWidth-1:0]    rsp_tdata,
   // entry_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_wen,
   input  logic [btksq_pkg::CapWidth-1:0]      csr_wdata
);
   import btksq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int ResetCap = (QUEUE_DEPTH < 32) ? QUEUE_DEPTH : 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMPTY_DRAIN
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  cap_ff, cap_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_user_ff, rsp_user_in;
   logic           rsp_last_ff, rsp_last_in;
   entry_type      rsp_data_ff, rsp_data_in;

   entry_type      new_entry;
   cell_ctrl_type  ctrl;
   logic           req_accept;
   logic           out_free;
   logic           wdata_over;
   entry_type      ent_w [QUEUE_DEPTH];
   logic           gt_w  [QUEUE_DEPTH];

   assign new_entry  = entry_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ctrl.insert = req_accept && (req_tuser == OP_INSERT);
   assign ctrl.drain  = (state_ff == ST_DRAIN) && out_free;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      btksq_cell u_cell (
         .clock      (clock),
         .occupied   (CW'(i) < count_ff),
         .prev_gt    ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i - 1]),
         .new_entry  (new_entry),
         .prev_entry (ent_w[(i == 0) ? 0 : i - 1]),
         .next_entry (ent_w[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .ctrl       (ctrl),
         .gt         (gt_w[i]),
         .entry      (ent_w[i])
      );
   end

   assign wdata_over = {1'b0, csr_wdata} > (CapWidth + 1)'(QUEUE_DEPTH);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;

      // Capacity only changes while the queue is empty; out-of-range values are clamped.
      if (csr_wen && (count_ff == '0)) begin
         if (csr_wdata == '0) begin
            cap_in = CW'(1);
         end else if (wdata_over) begin
            cap_in = CW'(QUEUE_DEPTH);
         end else begin
            cap_in = CW'(csr_wdata);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (ctrl.insert && (count_ff < cap_ff)) begin
               count_in = count_ff + CW'(1);
            end
            if (req_accept && (req_tuser == OP_DRAIN)) begin
               state_in = (count_ff == '0) ? ST_EMPTY_DRAIN : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = 1'b1;
               rsp_last_in  = (count_ff == CW'(1));
               rsp_data_in  = ent_w[0];
               count_in     = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CW'(ResetCap);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BTKSQ_NEVER(a_count_within_cap, clock, reset, count_ff > cap_ff, "entry count above capacity")
   `BTKSQ_ASSERT(a_drain_enters, clock, reset, req_accept && (req_tuser == OP_DRAIN) && (count_ff != '0) |=> state_ff == ST_DRAIN, "nonempty drain did not start")
   `BTKSQ_ASSERT(a_last_empties, clock, reset, ctrl.drain && (count_ff == CW'(1)) |=> count_ff == '0, "queue not empty after last beat")
   `BTKSQ_ASSERT(a_invalid_is_last, clock, reset, rsp_valid_ff && !rsp_user_ff |-> rsp_last_ff, "empty-drain beat without last mark")
   `BTKSQ_ASSERT(a_full_insert_keeps, clock, reset, ctrl.insert && (count_ff == cap_ff) |=> count_ff == $past(count_ff), "insert into full queue changed count")

endmodule
